// ----- sv/mhpq_pkg.sv -----
// Package for the min-heap priority queue: word types, entry type,
// field widths, kind and status codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mhpq_pkg;

  localparam int KeyW          = 31;
  localparam int NodeW         = 16;
  localparam int StatusW       = 2;
  localparam int CountW        = 11;
  localparam int DefHeapDepth  = 1024;

  localparam logic KIND_INSERT  = 1'b0;
  localparam logic KIND_EXTRACT = 1'b1;

  localparam logic [StatusW-1:0] STATUS_DONE  = 2'd0;
  localparam logic [StatusW-1:0] STATUS_FULL  = 2'd1;
  localparam logic [StatusW-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic             kind;
    logic [KeyW-1:0]  key;
    logic [NodeW-1:0] node;
  } mhpq_in_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [KeyW-1:0]    out_key;
    logic [NodeW-1:0]   out_node;
    logic [CountW-1:0]  count;
  } mhpq_out_t;

  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [NodeW-1:0] node;
  } mhpq_entry_t;

endpackage

`default_nettype wire

// ----- sv/mhpq_store.sv -----
// Heap entry memory: one write port, two read ports, registered read data.
// Depends on mhpq_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module mhpq_store #(
  parameter int HEAP_DEPTH = mhpq_pkg::DefHeapDepth
) (
  input  wire                                clk_i,
  input  wire                                wr_en_i,
  input  wire [$clog2(HEAP_DEPTH)-1:0]       wr_addr_i,
  input  mhpq_pkg::mhpq_entry_t              wr_data_i,
  input  wire [$clog2(HEAP_DEPTH)-1:0]       rd0_addr_i,
  input  wire [$clog2(HEAP_DEPTH)-1:0]       rd1_addr_i,
  output mhpq_pkg::mhpq_entry_t              rd0_data_o,
  output mhpq_pkg::mhpq_entry_t              rd1_data_o
);
  import mhpq_pkg::*;

  mhpq_entry_t mem [HEAP_DEPTH];
  mhpq_entry_t rd0_q;
  mhpq_entry_t rd1_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd0_q <= mem[rd0_addr_i];
    rd1_q <= mem[rd1_addr_i];
  end

  assign rd0_data_o = rd0_q;
  assign rd1_data_o = rd1_q;

endmodule

`default_nettype wire

// ----- sv/mhpq_seq.sv -----
// Sift sequencer: walks the moving entry up or down the heap one level at a
// time with a single shared key comparator. Depends on mhpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mhpq_seq #(
  parameter int HEAP_DEPTH = mhpq_pkg::DefHeapDepth
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               start_i,
  input  mhpq_pkg::mhpq_in_t                item_i,
  output logic                              busy_o,
  output logic                              done_o,
  output mhpq_pkg::mhpq_out_t               result_o,
  input  wire                               ack_i,
  output logic                              wr_en_o,
  output logic [$clog2(HEAP_DEPTH)-1:0]     wr_addr_o,
  output mhpq_pkg::mhpq_entry_t             wr_data_o,
  output logic [$clog2(HEAP_DEPTH)-1:0]     rd0_addr_o,
  output logic [$clog2(HEAP_DEPTH)-1:0]     rd1_addr_o,
  input  mhpq_pkg::mhpq_entry_t             rd0_data_i,
  input  mhpq_pkg::mhpq_entry_t             rd1_data_i
);
  import mhpq_pkg::*;

  localparam int AddrW = $clog2(HEAP_DEPTH);
  localparam int CntW  = $clog2(HEAP_DEPTH + 1);
  localparam int IdxW  = AddrW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_UP_RD, S_UP_CMP, S_EX_RD, S_EX_LD,
    S_DN_RD, S_DN_C1, S_DN_C2, S_DONE
  } state_e;

  state_e             state_q;
  logic [CntW-1:0]    cnt_q;
  logic [AddrW-1:0]   pos_q;
  mhpq_entry_t        mov_q;
  logic               best_lc_q;
  logic [StatusW-1:0] status_q;
  logic [KeyW-1:0]    okey_q;
  logic [NodeW-1:0]   onode_q;

  logic [IdxW-1:0]    lc;
  logic [IdxW-1:0]    rc;
  logic [IdxW-1:0]    cnt_x;
  logic               lc_ok;
  logic               rc_ok;
  logic [KeyW-1:0]    cmp_a;
  logic [KeyW-1:0]    cmp_b;
  logic               lt;
  logic               rc_win;

  // children of pos; the root's "left child" is itself and never wins
  assign lc    = {pos_q, 1'b0};
  assign rc    = {pos_q, 1'b1};
  assign cnt_x = IdxW'(cnt_q);
  assign lc_ok = (lc < cnt_x) && (pos_q != '0);
  assign rc_ok = rc < cnt_x;

  // shared comparator, operands picked by state
  always_comb begin
    unique case (state_q)
      S_UP_CMP: begin
        cmp_a = mov_q.key;
        cmp_b = rd0_data_i.key;
      end
      S_DN_C1: begin
        cmp_a = rd0_data_i.key;
        cmp_b = mov_q.key;
      end
      S_DN_C2: begin
        cmp_a = rd1_data_i.key;
        cmp_b = best_lc_q ? rd0_data_i.key : mov_q.key;
      end
      default: begin
        cmp_a = mov_q.key;
        cmp_b = mov_q.key;
      end
    endcase
  end

  assign lt     = cmp_a < cmp_b;
  assign rc_win = rc_ok && lt;

  always_comb begin
    unique case (state_q)
      S_EX_RD: begin
        rd0_addr_o = '0;
        rd1_addr_o = AddrW'(cnt_q - 1'b1);
      end
      S_UP_RD, S_UP_CMP: begin
        rd0_addr_o = pos_q >> 1;
        rd1_addr_o = rc[AddrW-1:0];
      end
      default: begin
        rd0_addr_o = lc[AddrW-1:0];
        rd1_addr_o = rc[AddrW-1:0];
      end
    endcase
  end

  // hole-based sift: the moving entry is written only where it settles
  always_comb begin
    wr_en_o   = 1'b0;
    wr_addr_o = pos_q;
    wr_data_o = mov_q;
    unique case (state_q)
      S_UP_RD: begin
        wr_en_o = (pos_q == '0);
      end
      S_UP_CMP: begin
        wr_en_o   = 1'b1;
        wr_data_o = lt ? rd0_data_i : mov_q;
      end
      S_DN_C2: begin
        wr_en_o   = 1'b1;
        wr_data_o = rc_win ? rd1_data_i : (best_lc_q ? rd0_data_i : mov_q);
      end
      default: begin
        wr_en_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      pos_q     <= '0;
      mov_q     <= '0;
      best_lc_q <= 1'b0;
      status_q  <= STATUS_DONE;
      okey_q    <= '0;
      onode_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            okey_q   <= '0;
            onode_q  <= '0;
            status_q <= STATUS_DONE;
            if (item_i.kind == KIND_INSERT) begin
              if (cnt_q == CntW'(HEAP_DEPTH)) begin
                status_q <= STATUS_FULL;
                state_q  <= S_DONE;
              end else begin
                mov_q   <= '{key: item_i.key, node: item_i.node};
                pos_q   <= AddrW'(cnt_q);
                cnt_q   <= cnt_q + 1'b1;
                state_q <= S_UP_RD;
              end
            end else begin
              if (cnt_q == '0) begin
                status_q <= STATUS_EMPTY;
                state_q  <= S_DONE;
              end else begin
                state_q <= S_EX_RD;
              end
            end
          end
        end
        S_UP_RD: begin
          state_q <= (pos_q == '0) ? S_DONE : S_UP_CMP;
        end
        S_UP_CMP: begin
          if (lt) begin
            pos_q   <= pos_q >> 1;
            state_q <= S_UP_RD;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_EX_RD: begin
          state_q <= S_EX_LD;
        end
        S_EX_LD: begin
          okey_q  <= rd0_data_i.key;
          onode_q <= rd0_data_i.node;
          mov_q   <= rd1_data_i;
          cnt_q   <= cnt_q - 1'b1;
          pos_q   <= '0;
          state_q <= S_DN_RD;
        end
        S_DN_RD: begin
          state_q <= S_DN_C1;
        end
        S_DN_C1: begin
          best_lc_q <= lc_ok && lt;
          state_q   <= S_DN_C2;
        end
        S_DN_C2: begin
          if (rc_win) begin
            pos_q   <= rc[AddrW-1:0];
            state_q <= S_DN_RD;
          end else if (best_lc_q) begin
            pos_q   <= lc[AddrW-1:0];
            state_q <= S_DN_RD;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (ack_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

  assign result_o.status   = status_q;
  assign result_o.out_key  = okey_q;
  assign result_o.out_node = onode_q;
  assign result_o.count    = CountW'(cnt_q);

endmodule

`default_nettype wire

// ----- sv/min_heap_priority_queue.sv -----
// Min-heap priority queue: insert sifts up (read, compare per level), extract
// sifts down (read, left compare, right compare per level) through one comparator
// and a 2-read/1-write memory; a sift crosses at most log2 depth levels.
// One word in flight; the next word is taken once the result is in the output reg.
// Reset empties the heap at once (count cleared); the memory is not swept.
// Depends on mhpq_pkg, mhpq_store, mhpq_seq.
`timescale 1ns / 1ps
`default_nettype none

module min_heap_priority_queue #(
  parameter int HEAP_DEPTH = mhpq_pkg::DefHeapDepth
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  mhpq_pkg::mhpq_in_t   in_word_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output mhpq_pkg::mhpq_out_t  out_word_o
);
  import mhpq_pkg::*;

  localparam int AddrW = $clog2(HEAP_DEPTH);

  logic               seq_busy;
  logic               seq_done;
  mhpq_out_t          seq_result;
  logic               seq_ack;
  logic               start;

  logic               wr_en;
  logic [AddrW-1:0]   wr_addr;
  mhpq_entry_t        wr_data;
  logic [AddrW-1:0]   rd0_addr;
  logic [AddrW-1:0]   rd1_addr;
  mhpq_entry_t        rd0_data;
  mhpq_entry_t        rd1_data;

  logic               out_valid_q;
  mhpq_out_t          out_word_q;

  // input side: take a word whenever the sequencer is idle
  assign in_stall_o = seq_busy;
  assign start      = in_valid_i && !seq_busy;

  // output register frees the sequencer as soon as its result lands here
  assign seq_ack = !out_valid_q || !out_stall_i;

  mhpq_store #(
    .HEAP_DEPTH(HEAP_DEPTH)
  ) u_store (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_data),
    .rd0_addr_i (rd0_addr),
    .rd1_addr_i (rd1_addr),
    .rd0_data_o (rd0_data),
    .rd1_data_o (rd1_data)
  );

  mhpq_seq #(
    .HEAP_DEPTH(HEAP_DEPTH)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .item_i     (in_word_i),
    .busy_o     (seq_busy),
    .done_o     (seq_done),
    .result_o   (seq_result),
    .ack_i      (seq_ack),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .rd0_addr_o (rd0_addr),
    .rd1_addr_o (rd1_addr),
    .rd0_data_i (rd0_data),
    .rd1_data_i (rd1_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
    end else begin
      if (seq_done && seq_ack) begin
        out_valid_q <= 1'b1;
        out_word_q  <= seq_result;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire
